// File: rtl/assert_macros.svh
// Assertion macros shared by the thermistor temperature unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check an implication or condition on every rising clock edge outside reset.
`define TATU_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
// Check that a condition never holds outside reset.
`define TATU_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("forbidden condition seen");
`else
`define TATU_ASSERT(lbl, clk, rstn, prop)
`define TATU_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// File: rtl/tatu_pkg.sv
// Types, constants and the calibration ROM of the thermistor temperature unit.
`default_nettype none
package tatu_pkg;

	localparam int DIVIDEND_W = 32;
	localparam int DIVISOR_W  = 17;
	localparam int ROM_LEN    = 50;
	localparam int IDX_W      = 6;
	localparam int TEMP_W     = 13;
	localparam int OHMS_W     = 17;
	localparam int VOLT_W     = 14;
	localparam int RES_W      = 30;

	localparam logic [12:0] FULL_MV = 13'd5000;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_COLD = 2'd1;
	localparam logic [1:0] ST_HOT  = 2'd2;

	localparam logic REG_ADC_OFFSET = 1'b0;
	localparam logic REG_DIVIDER    = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_DIV_V = 8'b0000_0010,
		S_CHK_V = 8'b0000_0100,
		S_DIV_R = 8'b0000_1000,
		S_CHK_R = 8'b0001_0000,
		S_WALK  = 8'b0010_0000,
		S_DIV_T = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	localparam logic [TEMP_W-1:0] ROM_TEMP [ROM_LEN] = '{
		13'd56,   13'd167,  13'd278,  13'd389,  13'd500,
		13'd611,  13'd722,  13'd833,  13'd944,  13'd1056,
		13'd1167, 13'd1278, 13'd1389, 13'd1500, 13'd1611,
		13'd1722, 13'd1833, 13'd1944, 13'd2056, 13'd2167,
		13'd2278, 13'd2389, 13'd2500, 13'd2611, 13'd2722,
		13'd2833, 13'd2944, 13'd3056, 13'd3167, 13'd3278,
		13'd3389, 13'd3500, 13'd3611, 13'd3722, 13'd3833,
		13'd3944, 13'd4056, 13'd4167, 13'd4278, 13'd4389,
		13'd4500, 13'd4611, 13'd4722, 13'd4833, 13'd4944,
		13'd5056, 13'd5167, 13'd5278, 13'd5389, 13'd5500
	};

	localparam logic [OHMS_W-1:0] ROM_OHMS [ROM_LEN] = '{
		17'd68057, 17'd64129, 17'd60451, 17'd57005, 17'd53777,
		17'd50750, 17'd47912, 17'd45249, 17'd42750, 17'd40383,
		17'd38180, 17'd36111, 17'd34165, 17'd32336, 17'd30615,
		17'd28996, 17'd27472, 17'd26037, 17'd24674, 17'd23400,
		17'd22200, 17'd21068, 17'd20001, 17'd18994, 17'd18043,
		17'd17145, 17'd16297, 17'd15488, 17'd14731, 17'd14016,
		17'd13339, 17'd12699, 17'd12092, 17'd11519, 17'd10975,
		17'd10461, 17'd9969,  17'd9507,  17'd9069,  17'd8654,
		17'd8260,  17'd7886,  17'd7531,  17'd7194,  17'd6874,
		17'd6567,  17'd6278,  17'd6004,  17'd5742,  17'd5494
	};

	function automatic logic [TEMP_W-1:0] rom_temp(input logic [IDX_W-1:0] i);
		if (i < IDX_W'(ROM_LEN))
			return ROM_TEMP[i];
		return '0;
	endfunction

	function automatic logic [OHMS_W-1:0] rom_ohms(input logic [IDX_W-1:0] i);
		if (i < IDX_W'(ROM_LEN))
			return ROM_OHMS[i];
		return '0;
	endfunction

endpackage
`default_nettype wire

// File: rtl/tatu_div.sv
// Shared restoring divider: one quotient bit per cycle.
`default_nettype none
`include "assert_macros.svh"
module tatu_div
	import tatu_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [DIVISOR_W-1:0]  divisor,
	output logic      [DIVIDEND_W-1:0] quotient,
	output div_stat_t                  stat
);

	localparam int CNT_W = $clog2(DIVIDEND_W);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  ge;

	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
			rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	`TATU_ASSERT(a_done_pulse, clk, arst_n, done_q |=> !done_q)
	`TATU_ASSERT(a_start_busy, clk, arst_n, (start && !busy_q) |=> busy_q)
	`TATU_ASSERT(a_done_after_busy, clk, arst_n, done_q |-> $past(busy_q))

endmodule
`default_nettype wire

// File: rtl/thermistor_adc_to_temperature_unit.sv
// Thermistor ADC sample to temperature: sequencer, shared multiplier and output register.
//
// Usage: each request on the s_ channel carries one raw ADC sample of the
// thermistor divider. The block converts it to millivolts, adds adc_offset_mv,
// derives the thermistor resistance from divider_ohms, walks the 50-entry
// calibration ROM and interpolates the temperature in hundredths of a degree.
// One result leaves on the m_ channel for every sample: temperature in tdata,
// range status in tuser (0 in table, 1 too cold, 2 too hot; temperature 0 then).
// The millivolt conversion folds the product by shift and add, one fold per
// cycle (up to three at the default 10-bit width). One shared 32-step divider
// serves the resistance and the interpolation, and the ROM walk takes one entry
// per cycle. A voltage out of range goes straight to the output; a resistance
// above the table leaves after the resistance division, one below the last entry
// after the full walk, and a match after the walk and the interpolating division.
// One sample is in work at a time; s_tready is high only while the sequencer
// is idle, so a new sample is taken only once the last one has left the sequencer.
// The result sits in an output register, so a new sample is taken while it waits;
// a stalled receiver holds the finished next result in the sequencer until taken.
// Configuration writes on cfg_ are always accepted and belong in idle periods.
// Reset clears the channels and loads offset -200 mV and divider 20000 ohms.
`default_nettype none
`include "assert_macros.svh"
module thermistor_adc_to_temperature_unit
	import tatu_pkg::*;
#(
	parameter int TABLE_ENTRIES = 50,
	parameter int ADC_BITS      = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [9:0] adc_sample
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata,   // [12:0] temp_centi
	output logic      [1:0]  m_tuser,   // [1:0] range_status
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [16:0] cfg_data
);

	localparam int LIMIT = (TABLE_ENTRIES < ROM_LEN) ? TABLE_ENTRIES : ROM_LEN;
	localparam logic [15:0] ADC_MASK = 16'((32'd1 << ADC_BITS) - 1);
	localparam int FOLD_W = ADC_BITS + 13;

	state_t                    state_q;
	logic signed [10:0]        offset_q;
	logic [OHMS_W-1:0]         divider_q;
	logic signed [VOLT_W-1:0]  v_q;
	logic [RES_W-1:0]          r_q;
	logic [IDX_W-1:0]          idx_q;
	logic [TEMP_W-1:0]         temp_q;
	logic [1:0]                status_q;
	logic [TEMP_W-1:0]         out_temp_q;
	logic [1:0]                out_status_q;
	logic                      m_tvalid_q;
	logic [FOLD_W-1:0]         fold_q;
	logic [12:0]               acc_q;

	logic [15:0]               adc;
	logic [IDX_W-1:0]          idx_m1;
	logic [OHMS_W-1:0]         ohms_i;
	logic [OHMS_W-1:0]         ohms_p;
	logic [TEMP_W-1:0]         temp_i;
	logic [TEMP_W-1:0]         temp_p;
	logic [OHMS_W-1:0]         dr;
	logic [OHMS_W-1:0]         r_excess;
	logic [16:0]               mul_a;
	logic [16:0]               mul_b;
	logic [33:0]               product;
	logic                      div_start;
	logic [DIVIDEND_W-1:0]     div_dividend;
	logic [DIVISOR_W-1:0]      div_divisor;
	logic [DIVIDEND_W-1:0]     div_quo;
	div_stat_t                 div_stat;
	logic [FOLD_W-1:0]         fold_hi;
	logic [FOLD_W-1:0]         fold_lo;
	logic [FOLD_W-1:0]         fold_next;
	logic                      fold_done;
	logic [12:0]               volt_mv;
	logic signed [VOLT_W-1:0]  v_next;
	logic                      out_free;

	assign adc    = {6'd0, s_tdata[9:0]} & ADC_MASK;
	assign idx_m1 = idx_q - 1'b1;
	assign ohms_i = rom_ohms(idx_q);
	assign ohms_p = rom_ohms(idx_m1);
	assign temp_i = rom_temp(idx_q);
	assign temp_p = rom_temp(idx_m1);
	assign dr     = ohms_p - ohms_i;
	assign r_excess = r_q[OHMS_W-1:0] - ohms_i;

	// Divide by 2^ADC_BITS - 1: fold the high part onto the low part until it fits.
	assign fold_hi   = fold_q >> ADC_BITS;
	assign fold_lo   = fold_q & FOLD_W'(ADC_MASK);
	assign fold_next = fold_hi + fold_lo;
	assign fold_done = (fold_hi == '0);
	assign volt_mv   = acc_q + 13'(fold_q == FOLD_W'(ADC_MASK));

	assign v_next = signed'({1'b0, volt_mv}) + VOLT_W'(offset_q);
	assign out_free = !m_tvalid_q || m_tready;

	tatu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	// Shared multiplier and divider operand selection.
	always_comb begin
		mul_a        = {1'b0, adc};
		mul_b        = 17'(FULL_MV);
		div_start    = 1'b0;
		div_divisor  = '0;
		div_dividend = product[DIVIDEND_W-1:0];
		case (state_q)
			S_CHK_V: begin
				mul_a       = {4'd0, v_q[12:0]};
				mul_b       = divider_q;
				div_divisor = {4'd0, FULL_MV - v_q[12:0]};
				div_start   = (v_q < signed'(VOLT_W'(FULL_MV))) && (v_q > 0);
			end
			S_WALK: begin
				mul_a        = 17'(temp_i - temp_p);
				mul_b        = r_excess;
				div_divisor  = dr;
				div_dividend = product[DIVIDEND_W-1:0] + DIVIDEND_W'(dr) - 1'b1;
				div_start    = (idx_q < IDX_W'(LIMIT)) && (r_q[OHMS_W-1:0] >= ohms_i);
			end
			default: begin
			end
		endcase
	end

	assign product = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			offset_q   <= -11'sd200;
			divider_q  <= 17'd20000;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_ADC_OFFSET: offset_q  <= signed'(cfg_data[10:0]);
					REG_DIVIDER:    divider_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == S_OUT && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid)
						state_q <= S_DIV_V;
				end
				S_DIV_V: begin
					if (fold_done)
						state_q <= S_CHK_V;
				end
				S_CHK_V: begin
					state_q <= div_start ? S_DIV_R : S_OUT;
				end
				S_DIV_R: begin
					if (div_stat.done)
						state_q <= S_CHK_R;
				end
				S_CHK_R: begin
					state_q <= (r_q > RES_W'(rom_ohms('0))) ? S_OUT : S_WALK;
				end
				S_WALK: begin
					if (idx_q >= IDX_W'(LIMIT) || div_start)
						state_q <= div_start ? S_DIV_T : S_OUT;
				end
				S_DIV_T: begin
					if (div_stat.done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					fold_q <= product[FOLD_W-1:0];
					acc_q  <= '0;
				end
			end
			S_DIV_V: begin
				if (fold_done) begin
					v_q <= v_next;
				end else begin
					fold_q <= fold_next;
					acc_q  <= acc_q + fold_hi[12:0];
				end
			end
			S_CHK_V: begin
				temp_q <= '0;
				if (v_q >= signed'(VOLT_W'(FULL_MV)))
					status_q <= ST_COLD;
				else
					status_q <= ST_HOT;
			end
			S_DIV_R: begin
				if (div_stat.done) begin
					r_q   <= div_quo[RES_W-1:0];
					idx_q <= IDX_W'(1);
				end
			end
			S_CHK_R: begin
				status_q <= ST_COLD;
			end
			S_WALK: begin
				status_q <= ST_HOT;
				if (!div_start && idx_q < IDX_W'(LIMIT))
					idx_q <= idx_q + 1'b1;
			end
			S_DIV_T: begin
				if (div_stat.done) begin
					temp_q   <= temp_i - div_quo[TEMP_W-1:0];
					status_q <= ST_OK;
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_temp_q   <= temp_q;
					out_status_q <= status_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {3'd0, out_temp_q};
	assign m_tuser   = out_status_q;

	`TATU_NEVER(a_start_while_busy, clk, arst_n, div_start && div_stat.busy)
	`TATU_ASSERT(a_valid_from_out, clk, arst_n, $rose(m_tvalid_q) |-> $past(state_q == S_OUT))
	`TATU_ASSERT(a_zero_off_table, clk, arst_n,
		(m_tvalid_q && out_status_q != ST_OK) |-> (out_temp_q == '0))
	`TATU_NEVER(a_idx_limit, clk, arst_n, state_q == S_WALK && idx_q > IDX_W'(LIMIT))

endmodule
`default_nettype wire
